/* rtl/core/hrq_pkg.sv */
`default_nettype none

package hrq_pkg;

    // Field and bus widths
    localparam int HEADING_W   = 24;
    localparam int FIELD_W     = 18;
    localparam int NUM_FIELDS  = 6;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 112;
    localparam int TABLE_LEN   = 30;

    // Internal angle and datapath widths (Q.30)
    localparam int AW = 35;                 // raw angle before wrap
    localparam int CW = 34;                 // CORDIC x, y, z
    localparam int RW = CW + 1 - 14;        // rounded value before clamp
    localparam int FRAC_DROP = 14;

    localparam logic signed [AW-1:0] ANG_PI     = 35'sd3373259426;
    localparam logic signed [AW-1:0] ANG_TWO_PI = 35'sd6746518852;
    localparam logic signed [CW-1:0] FOLD_PI    = 34'sd3373259426;
    localparam logic signed [CW-1:0] FOLD_HALF  = 34'sd1686629713;
    localparam logic signed [CW-1:0] GAIN_INV   = 34'sd652032874;
    localparam logic signed [CW:0]   ROUND_BIAS = 35'sd8192;
    localparam logic signed [RW-1:0] ONE_Q16    = 21'sd65536;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 neg;
    } lane_t;

    typedef struct packed {
        lane_t full;
        lane_t half;
    } pair_t;

    typedef struct packed {
        logic signed [RW-1:0] cf;
        logic signed [RW-1:0] sf;
        logic signed [RW-1:0] ch;
        logic signed [RW-1:0] sh;
    } rnd_t;

    // Arctangent of 2^-k in Q.30
    function automatic logic signed [CW-1:0] atan_q30(input int unsigned k);
        logic [31:0] v;
        case (k)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            default: v = 32'h0;
        endcase
        return signed'({{(CW-32){1'b0}}, v});
    endfunction

    // Bring an angle into [-pi, pi); one turn of correction covers the input range
    function automatic logic signed [CW-1:0] wrap_ang(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] r;
        if (a >= ANG_PI) begin
            r = a - ANG_TWO_PI;
        end else if (a < -ANG_PI) begin
            r = a + ANG_TWO_PI;
        end else begin
            r = a;
        end
        return r[CW-1:0];
    endfunction

    // Fold into [-pi/2, pi/2] and seed the rotation vector
    function automatic lane_t fold_ang(input logic signed [CW-1:0] a);
        lane_t l;
        l.x = GAIN_INV;
        l.y = '0;
        if (a > FOLD_HALF) begin
            l.z   = a - FOLD_PI;
            l.neg = 1'b1;
        end else if (a < -FOLD_HALF) begin
            l.z   = a + FOLD_PI;
            l.neg = 1'b1;
        end else begin
            l.z   = a;
            l.neg = 1'b0;
        end
        return l;
    endfunction

    // One rotation-mode micro-rotation
    function automatic lane_t cordic_step(input lane_t l, input int unsigned k);
        lane_t o;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        dx = l.y >>> k;
        dy = l.x >>> k;
        o  = l;
        if (!l.z[CW-1]) begin
            o.x = l.x - dx;
            o.y = l.y + dy;
            o.z = l.z - atan_q30(k);
        end else begin
            o.x = l.x + dx;
            o.y = l.y - dy;
            o.z = l.z + atan_q30(k);
        end
        return o;
    endfunction

    // Apply the fold sign and round Q.30 to Q.16 (floor after half-LSB bias)
    function automatic logic signed [RW-1:0] round_q16(input logic signed [CW-1:0] v,
                                                      input logic neg);
        logic signed [CW:0] ve;
        logic signed [CW:0] sum;
        ve  = {v[CW-1], v};
        sum = neg ? (ROUND_BIAS - ve) : (ve + ROUND_BIAS);
        return sum[CW:FRAC_DROP];
    endfunction

    // Clamp to [-1, 1] in Q1.16
    function automatic logic [FIELD_W-1:0] sat_q16(input logic signed [RW-1:0] r);
        logic signed [RW-1:0] c;
        if (r > ONE_Q16) begin
            c = ONE_Q16;
        end else if (r < -ONE_Q16) begin
            c = -ONE_Q16;
        end else begin
            c = r;
        end
        return c[FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/heading_to_rotation_and_quaternion_unit.sv */
`default_nettype none
// Heading to upright rotation matrix and half-angle quaternion.
// Input stream (s_): one signed Q4.20 heading in radians per request.
// Output stream (m_): cos a, sin a, -sin a, cos a, cos(a/2), sin(a/2), each
// signed Q1.16 clamped to [-1, 1], packed 18 bits apiece from bit 0 upward.
// Two CORDIC lanes (full and half angle) run side by side in one pipeline:
// a wrap stage, a fold stage, one stage per micro-rotation, a rounding stage
// and the output register, min(CORDIC_STEPS, 30) + 4 register stages in all.
// Throughput is one request per cycle while m_tready does not stall the pipe,
// set by the one-step-per-stage layout. Each stage holds its own valid bit and loads when it is empty or when the
// stage after it moves, so bubbles collapse and s_tready stays high while the
// pipe has room, even with a finished result waiting on m_tready.
// A stall on m_tready holds m_tdata steady and backs up stage by stage; no
// request is dropped or repeated.
// Reset (aresetn low, synchronous) empties every stage; outputs read invalid
// on the next cycle. No state survives between requests.
module heading_to_rotation_and_quaternion_unit #(
    parameter int CORDIC_STEPS = 18
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [hrq_pkg::S_TDATA_W-1:0] s_tdata,  // [23:0] heading
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [17:0] row0_x, [35:18] row0_y, [53:36] row1_x, [71:54] row1_y,
    // [89:72] quat_w, [107:90] quat_z, [111:108] zero
    output logic [hrq_pkg::M_TDATA_W-1:0]      m_tdata
);
    import hrq_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int NP    = NSTEP + 2;

    logic [NP-1:0] vld_reg;
    pair_t         pipe_reg  [NP];
    pair_t         pipe_next [NP];
    logic [NP:0]   rdy;

    logic          rnd_vld_reg;
    rnd_t          rnd_reg;
    rnd_t          rnd_next;
    logic          rnd_rdy;

    logic                  out_vld_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;
    logic [M_TDATA_W-1:0]  out_data_next;
    logic                  out_rdy;

    logic signed [HEADING_W-1:0] hdg;
    logic signed [AW-1:0]        ang_full;
    logic signed [AW-1:0]        ang_half;

    // Ready chain: a stage loads when it is empty or its successor moves
    assign out_rdy = m_tready || !out_vld_reg;
    assign rnd_rdy = !rnd_vld_reg || out_rdy;
    assign rdy[NP] = rnd_rdy;
    assign s_tready = rdy[0];

    // Scale heading to Q.30 full and half angles
    assign hdg      = signed'(s_tdata[HEADING_W-1:0]);
    assign ang_full = {hdg[HEADING_W-1], hdg, 10'b0};
    assign ang_half = {{2{hdg[HEADING_W-1]}}, hdg, 9'b0};

    // Wrap stage
    always_comb begin
        pipe_next[0]        = '0;
        pipe_next[0].full.z = wrap_ang(ang_full);
        pipe_next[0].half.z = wrap_ang(ang_half);
    end

    // Fold stage
    always_comb begin
        pipe_next[1].full = fold_ang(pipe_reg[0].full.z);
        pipe_next[1].half = fold_ang(pipe_reg[0].half.z);
    end

    // Micro-rotation stages
    for (genvar i = 2; i < NP; i++) begin : g_step
        always_comb begin
            pipe_next[i].full = cordic_step(pipe_reg[i-1].full, i - 2);
            pipe_next[i].half = cordic_step(pipe_reg[i-1].half, i - 2);
        end
    end

    // Advance the main pipe
    for (genvar i = 0; i < NP; i++) begin : g_stage
        assign rdy[i] = !vld_reg[i] || rdy[i+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (rdy[i]) begin
                vld_reg[i] <= (i == 0) ? s_tvalid : vld_reg[(i == 0) ? 0 : i - 1];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[i]) begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    // Round stage: apply fold sign, drop to Q.16
    always_comb begin
        rnd_next.cf = round_q16(pipe_reg[NP-1].full.x, pipe_reg[NP-1].full.neg);
        rnd_next.sf = round_q16(pipe_reg[NP-1].full.y, pipe_reg[NP-1].full.neg);
        rnd_next.ch = round_q16(pipe_reg[NP-1].half.x, pipe_reg[NP-1].half.neg);
        rnd_next.sh = round_q16(pipe_reg[NP-1].half.y, pipe_reg[NP-1].half.neg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_vld_reg <= 1'b0;
        end else if (rnd_rdy) begin
            rnd_vld_reg <= vld_reg[NP-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (rnd_rdy) begin
            rnd_reg <= rnd_next;
        end
    end

    // Output stage: clamp and pack
    always_comb begin
        logic [FIELD_W-1:0] c_full;
        c_full        = sat_q16(rnd_reg.cf);
        out_data_next = {
            {(M_TDATA_W - NUM_FIELDS * FIELD_W){1'b0}},
            sat_q16(rnd_reg.sh),
            sat_q16(rnd_reg.ch),
            c_full,
            sat_q16(-rnd_reg.sf),
            sat_q16(rnd_reg.sf),
            c_full
        };
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_rdy) begin
            out_vld_reg <= rnd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_rdy) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* rtl/core/hrq_checker.sv */
`default_nettype none

module hrq_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [hrq_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [hrq_pkg::M_TDATA_W-1:0] m_tdata
);
    import hrq_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or vanished");

    // Quarter-turn row: row1_y repeats row0_x
    a_row1_y: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[71:54] == m_tdata[17:0])
        else $error("row1_y differs from row0_x");

    // Quarter-turn row: row1_x is the negated row0_y
    a_row1_x: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[53:36] == 18'(~m_tdata[35:18] + 18'd1))
        else $error("row1_x is not the negated row0_y");

    // Padding bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:NUM_FIELDS*FIELD_W] == '0)
        else $error("padding bits set");

    // Reset empties the pipe
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

endmodule

bind heading_to_rotation_and_quaternion_unit hrq_checker u_hrq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/sv/testbench.sv */
`default_nettype none

module testbench;

    localparam int CORDIC_STEPS = 18;
    localparam int ROTATIONS    = (CORDIC_STEPS > 30) ? 30 : CORDIC_STEPS;
    localparam int PIPE_DEPTH   = ROTATIONS + 4;
    localparam int CYCLE_LIMIT  = 1000000;

    localparam longint Q30_PI       = 64'sd3373259426;
    localparam longint Q30_HALF_PI  = 64'sd1686629713;
    localparam longint Q30_TWO_PI   = 64'sd6746518852;
    localparam longint Q30_GAIN_INV = 64'sd652032874;
    localparam longint Q30_HALF_LSB = 64'sd8192;
    localparam longint Q16_ONE      = 64'sd65536;

    typedef struct packed {
        logic [17:0] row0_x;
        logic [17:0] row0_y;
        logic [17:0] row1_x;
        logic [17:0] row1_y;
        logic [17:0] quat_w;
        logic [17:0] quat_z;
    } pose_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [hrq_pkg::S_TDATA_W-1:0]   s_tdata  = '0;  // [23:0] heading
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // [17:0] row0_x, [35:18] row0_y, [53:36] row1_x, [71:54] row1_y,
    // [89:72] quat_w, [107:90] quat_z, [111:108] zero
    logic [hrq_pkg::M_TDATA_W-1:0]   m_tdata;

    // Arctangent of 2^-k in Q.30 radians
    longint arctan_q30 [0:29] = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76,
        'h01FFD55B, 'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD,
        'h000FFFFF, 'h0007FFFF, 'h0003FFFF, 'h0001FFFF, 'h0000FFFF,
        'h00007FFF, 'h00003FFF, 'h00001FFF, 'h00000FFF, 'h000007FF,
        'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F, 'h0000003F,
        'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002
    };

    // Headings right at the wrap and fold thresholds of both lanes, plus the range ends, zero and one radian
    int wrap_fold_points [0:9] = '{
        1647100, -1647100, 3294199, -3294199, 6588398,
        -6588398, 8388607, -8388608, 0, 1048576
    };

    pose_t expected_poses [$];
    int    fail_count   = 0;
    int    results_seen = 0;
    int    items_sent   = 0;
    int    cycle_count  = 0;
    int    stall_left   = 0;
    bit    idle_on      = 1'b1;

    heading_to_rotation_and_quaternion_unit #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Round Q.30 to Q1.16 with a half-LSB bias, then clamp to one
    function automatic longint round_to_q16(input longint v);
        longint r;
        r = (v + Q30_HALF_LSB) >>> 14;
        if (r > Q16_ONE) begin
            r = Q16_ONE;
        end else if (r < -Q16_ONE) begin
            r = -Q16_ONE;
        end
        return r;
    endfunction

    // Wrap, fold and rotate one Q.30 angle; return cos and sin in Q1.16
    function automatic void rotate_angle(input longint angle,
                                         output longint cos_q16,
                                         output longint sin_q16);
        longint a;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        a = angle;
        repeat (2) begin
            if (a >= Q30_PI) a -= Q30_TWO_PI;
            if (a < -Q30_PI) a += Q30_TWO_PI;
        end
        // shift by pi into the right half plane; both outputs change sign
        flip = 1'b0;
        if (a > Q30_HALF_PI) begin
            a -= Q30_PI;
            flip = 1'b1;
        end else if (a < -Q30_HALF_PI) begin
            a += Q30_PI;
            flip = 1'b1;
        end
        x = Q30_GAIN_INV;
        y = 0;
        z = a;
        for (int k = 0; k < ROTATIONS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= arctan_q30[k];
            end else begin
                x += dx;
                y -= dy;
                z += arctan_q30[k];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cos_q16 = round_to_q16(x);
        sin_q16 = round_to_q16(y);
    endfunction

    // Work out the matrix rows and quaternion parts for one heading
    function automatic pose_t predict_pose(input logic [23:0] raw);
        longint heading;
        longint c;
        longint s;
        longint neg_s;
        longint hc;
        longint hs;
        pose_t  p;
        heading = $signed(raw);
        rotate_angle(heading * 1024, c, s);
        rotate_angle(heading * 512, hc, hs);
        neg_s    = -s;
        p.row0_x = c[17:0];
        p.row0_y = s[17:0];
        p.row1_x = neg_s[17:0];
        p.row1_y = c[17:0];
        p.quat_w = hc[17:0];
        p.quat_z = hs[17:0];
        return p;
    endfunction

    // Mostly short idles, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Stall the result side at random while idling is on
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 99) < 20) begin
            m_tready   <= 1'b0;
            stall_left <= idle_length() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [17:0] want,
                               input logic [17:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            fail_count++;
        end
    endtask

    // Queue a prediction per accepted request, check each delivered result
    always @(posedge aclk) begin
        pose_t want;
        pose_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_poses.push_back(predict_pose(s_tdata[23:0]));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[107:0];
                got = '{row0_x: m_tdata[17:0],  row0_y: m_tdata[35:18],
                        row1_x: m_tdata[53:36], row1_y: m_tdata[71:54],
                        quat_w: m_tdata[89:72], quat_z: m_tdata[107:90]};
                if (expected_poses.size() == 0) begin
                    $error("result delivered with no request pending");
                    fail_count++;
                end else begin
                    want = expected_poses.pop_front();
                    check_field("row0_x", want.row0_x, got.row0_x);
                    check_field("row0_y", want.row0_y, got.row0_y);
                    check_field("row1_x", want.row1_x, got.row1_x);
                    check_field("row1_y", want.row1_y, got.row1_y);
                    check_field("quat_w", want.quat_w, got.quat_w);
                    check_field("quat_z", want.quat_z, got.quat_z);
                    results_seen++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one heading, with an optional idle first; hold until accepted
    task automatic send_heading(input logic [23:0] heading);
        int gap;
        gap = (idle_on && $urandom_range(0, 99) < 30) ? idle_length() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= heading;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic test_corner_headings();
        int corners [0:21] = '{
            0, 1, -1, 8388607, -8388608,
            1647099, 1647100, -1647099, -1647100,
            3294198, 3294199, -3294198, -3294199,
            6588397, 6588398, -6588397, -6588398,
            1048576, -1048576, 4194304, 'h555555, -5592406
        };
        foreach (corners[i]) send_heading(24'(corners[i]));
    endtask

    task automatic test_random_headings(input int count);
        repeat (count) send_heading(24'($urandom()));
    endtask

    // Full rate on both sides once any running stall ends: no input gaps, no new output stalls
    task automatic test_back_to_back(input int count);
        idle_on = 1'b0;
        repeat (count) send_heading(24'($urandom()));
        idle_on = 1'b1;
    endtask

    // Hover around the wrap and fold thresholds, the range ends, one radian and tiny angles
    task automatic test_wrap_and_fold_edges(input int count);
        int base;
        repeat (count) begin
            base = wrap_fold_points[$urandom_range(0, 9)];
            send_heading(24'(base + int'($urandom_range(0, 12)) - 6));
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_corner_headings();
        test_random_headings(1150);
        test_back_to_back(330);
        test_wrap_and_fold_edges(350);

        // Drop the request line and drain the pipe
        s_tvalid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 8) @(posedge aclk);

        $display("Sent %0d headings: corners, uniform random, back-to-back, wrap/fold edges.",
                 items_sent);
        $display("Checked %0d rotation and quaternion results, %0d mismatches.",
                 results_seen, fail_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
